// File: rtl/core/cbhf_pkg.sv
// Shared types, constants and mask helpers for the horizontal span fill block.
`timescale 1ns / 1ps
`default_nettype none
package cbhf_pkg;

	localparam int unsigned ADDR_W    = 14;
	localparam int unsigned CPR_W     = 6;
	localparam int unsigned X_W       = 9;
	localparam int unsigned Y_W       = 8;
	localparam int unsigned LEN_W     = 9;
	localparam int unsigned CELL_W    = 6;
	localparam int unsigned REM_W     = 6;
	localparam int unsigned BIT_IDX_W = 3;

	localparam logic [LEN_W-1:0]     MAX_SPAN     = 9'd320;
	localparam logic [CPR_W-1:0]     CPR_RESET    = 6'd40;
	localparam logic [BIT_IDX_W-1:0] MUL_LAST_BIT = 3'd5;

	// Operand selection for the shared address adder.
	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_MUL    = 2'd1;
	localparam logic [1:0] OP_OFFSET = 2'd2;
	localparam logic [1:0] OP_STEP   = 2'd3;

	typedef struct packed {
		logic                 clear;
		logic [1:0]           op;
		logic [BIT_IDX_W-1:0] bit_idx;
	} addr_cmd_t;

	// Leftmost pixel is the MSB, so the left edge keeps the low bits.
	function automatic logic [7:0] left_mask(input logic [2:0] x_lo);
		left_mask = 8'hff >> x_lo;
	endfunction

	function automatic logic [7:0] right_mask(input logic [2:0] end_lo);
		right_mask = 8'hff << (3'd7 - end_lo);
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/cbhf_addr_unit.sv
// Shared address adder: shift-add row multiply, cell offset, and per-write step.
`timescale 1ns / 1ps
`default_nettype none
module cbhf_addr_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cbhf_pkg::addr_cmd_t          cmd,
	input  wire logic [cbhf_pkg::CPR_W-1:0]   cpr,
	input  wire logic [4:0]                   y_cell,
	input  wire logic [2:0]                   y_lo,
	input  wire logic [cbhf_pkg::CELL_W-1:0]  first_cell,
	output      logic [cbhf_pkg::ADDR_W-1:0]  addr
);

	logic [cbhf_pkg::ADDR_W-1:0] acc_q;
	logic [cbhf_pkg::ADDR_W-1:0] operand;
	logic [cbhf_pkg::ADDR_W-1:0] row_term;
	logic [cbhf_pkg::ADDR_W-1:0] sum;

	// (y & 0xf8) shifted by the current multiplier bit position.
	assign row_term = cbhf_pkg::ADDR_W'({y_cell, 3'b000}) << cmd.bit_idx;

	always_comb begin
		case (cmd.op)
			cbhf_pkg::OP_MUL:    operand = cpr[cmd.bit_idx] ? row_term : '0;
			cbhf_pkg::OP_OFFSET: operand = cbhf_pkg::ADDR_W'({first_cell, y_lo});
			cbhf_pkg::OP_STEP:   operand = cbhf_pkg::ADDR_W'(8);
			default:             operand = '0;
		endcase
	end

	assign sum = acc_q + operand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.clear) begin
			acc_q <= '0;
		end else begin
			acc_q <= sum;
		end
	end

	assign addr = acc_q;

endmodule
`default_nettype wire

// File: rtl/core/cell_bitmap_hspan_fill.sv
// Top level of the horizontal span fill block for a cell-organized 1-bit bitmap.
`timescale 1ns / 1ps
`default_nettype none
// A span request is taken when in_valid is high and in_stall is low; the block then
// stalls its input until the last byte write of the span has been transferred. One
// shared 14-bit adder does all address work: a shift-add over the six bits of
// cells_per_row forms the cell row base, the ST_OFFSET step adds the starting cell and
// the pixel line, and then the adder steps the address by 8 after each byte write that
// is transferred. A span touches 1 to 41 bytes, and a zero-length request is dropped in
// the cycle it is taken.
// cells_per_row may be written only while no span is in progress.
module cell_bitmap_hspan_fill (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [cbhf_pkg::CPR_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [cbhf_pkg::X_W-1:0]      x_start,
	input  wire logic [cbhf_pkg::Y_W-1:0]      y_line,
	input  wire logic [cbhf_pkg::LEN_W-1:0]    span_length,
	input  wire logic                          pixel_colour,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [cbhf_pkg::ADDR_W-1:0]   byte_address,
	output      logic [7:0]                    bit_mask,
	output      logic                          write_value,
	output      logic                          last_write
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MUL    = 2'd1;
	localparam logic [1:0] ST_OFFSET = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]                      state_q;
	logic [cbhf_pkg::CPR_W-1:0]      cpr_q;
	logic [cbhf_pkg::BIT_IDX_W-1:0]  bit_idx_q;
	logic [cbhf_pkg::REM_W-1:0]      rem_q;
	logic                            first_q;
	logic [2:0]                      x_lo_q;
	logic [2:0]                      end_lo_q;
	logic [4:0]                      y_cell_q;
	logic [2:0]                      y_lo_q;
	logic [cbhf_pkg::CELL_W-1:0]     first_cell_q;
	logic                            colour_q;

	logic                            in_xfer;
	logic                            out_xfer;
	logic [cbhf_pkg::LEN_W-1:0]      len_sat;
	logic [cbhf_pkg::X_W:0]          end_px;
	logic [cbhf_pkg::X_W-3:0]        cell_diff;
	logic [7:0]                      mask_l;
	logic [7:0]                      mask_r;
	cbhf_pkg::addr_cmd_t             cmd;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_valid = (state_q == ST_EMIT);
	assign out_xfer = out_valid && !out_stall;

	assign len_sat = (span_length > cbhf_pkg::MAX_SPAN) ? cbhf_pkg::MAX_SPAN : span_length;
	assign end_px = {1'b0, x_start} + {1'b0, len_sat} - (cbhf_pkg::X_W+1)'(1);
	// Last touched cell minus first; at most 40 for a saturated span.
	assign cell_diff = end_px[cbhf_pkg::X_W:3] - {1'b0, x_start[cbhf_pkg::X_W-1:3]};

	always_comb begin
		cmd.clear   = in_xfer;
		cmd.bit_idx = bit_idx_q;
		case (state_q)
			ST_MUL:    cmd.op = cbhf_pkg::OP_MUL;
			ST_OFFSET: cmd.op = cbhf_pkg::OP_OFFSET;
			ST_EMIT:   cmd.op = out_xfer ? cbhf_pkg::OP_STEP : cbhf_pkg::OP_NONE;
			default:   cmd.op = cbhf_pkg::OP_NONE;
		endcase
	end

	cbhf_addr_unit u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cpr        (cpr_q),
		.y_cell     (y_cell_q),
		.y_lo       (y_lo_q),
		.first_cell (first_cell_q),
		.addr       (byte_address)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q <= cbhf_pkg::CPR_RESET;
		end else if (cfg_wr_en) begin
			cpr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_idx_q <= '0;
			rem_q     <= '0;
			first_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// A zero-length request produces no writes and is simply dropped.
					if (in_xfer && (span_length != '0)) begin
						state_q   <= ST_MUL;
						bit_idx_q <= '0;
						rem_q     <= cell_diff[cbhf_pkg::REM_W-1:0];
						first_q   <= 1'b1;
					end
				end
				ST_MUL: begin
					bit_idx_q <= bit_idx_q + cbhf_pkg::BIT_IDX_W'(1);
					if (bit_idx_q == cbhf_pkg::MUL_LAST_BIT) begin
						state_q <= ST_OFFSET;
					end
				end
				ST_OFFSET: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_xfer) begin
						first_q <= 1'b0;
						rem_q   <= rem_q - cbhf_pkg::REM_W'(1);
						if (rem_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields, captured at the input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_lo_q       <= x_start[2:0];
			end_lo_q     <= end_px[2:0];
			y_cell_q     <= y_line[7:3];
			y_lo_q       <= y_line[2:0];
			first_cell_q <= x_start[cbhf_pkg::X_W-1:3];
			colour_q     <= pixel_colour;
		end
	end

	assign mask_l = first_q ? cbhf_pkg::left_mask(x_lo_q) : 8'hff;
	assign mask_r = (rem_q == '0) ? cbhf_pkg::right_mask(end_lo_q) : 8'hff;

	assign bit_mask    = mask_l & mask_r;
	assign write_value = colour_q;
	assign last_write  = (rem_q == '0);

endmodule
`default_nettype wire

// File: verif/tb_cell_bitmap_hspan_fill.sv
// Self-checking testbench for the horizontal span fill block of a cell-organized bitmap.
`timescale 1ns / 1ps
module tb_cell_bitmap_hspan_fill;
	import cbhf_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_SPANS  = 50;
	localparam int N_ROWS       = 20;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [7:0]        mask;
		logic              value;
		logic              last;
	} byte_write_t;

	typedef struct packed {
		logic [X_W-1:0]    x;
		logic [Y_W-1:0]    y;
		logic [LEN_W-1:0]  len;
		logic              colour;
		logic              typed;
		logic              typed_one;
		logic [ADDR_W-1:0] typed_addr;
		logic [7:0]        typed_mask;
	} span_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CPR_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [X_W-1:0]    x_start = '0;
	logic [Y_W-1:0]    y_line = '0;
	logic [LEN_W-1:0]  span_length = '0;
	logic              pixel_colour = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ADDR_W-1:0] byte_address;
	logic [7:0]        bit_mask;
	logic              write_value;
	logic              last_write;

	byte_write_t       pending_writes[$];
	logic [CPR_W-1:0]  width_cells = CPR_RESET;
	int                mismatches = 0;
	int                cycles = 0;
	logic              tx_idle = 1'b1;
	logic              rx_idle = 1'b1;
	logic              hold_outputs = 1'b0;
	span_row_t         rows[N_ROWS];

	cell_bitmap_hspan_fill i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_start     (x_start),
		.y_line      (y_line),
		.span_length (span_length),
		.pixel_colour(pixel_colour),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_address(byte_address),
		.bit_mask    (bit_mask),
		.write_value (write_value),
		.last_write  (last_write)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_cell_bitmap_hspan_fill failed");
			$finish;
		end
	end

	// Expands one span into its masked byte writes, left to right.
	function automatic void plan_span_writes(input logic [X_W-1:0] xs,
			input logic [Y_W-1:0] yl, input logic [LEN_W-1:0] ln, input logic col);
		int unsigned n, tail, c0, c1, base, k, m;
		byte_write_t w;
		if (ln == 0)
			return;
		n = (ln > MAX_SPAN) ? int'(MAX_SPAN) : int'(ln);
		tail = int'(xs) + n - 1;
		c0 = int'(xs) >> 3;
		c1 = tail >> 3;
		base = int'(width_cells) * (int'(yl) & 'hf8) + (int'(yl) & 'h07);
		for (k = c0; k <= c1; k++) begin
			m = 'hff;
			if (k == c0)
				m = m >> (int'(xs) & 7);
			if (k == c1)
				m = m & (('hff << (7 - (tail & 7))) & 'hff);
			w.addr = ADDR_W'((base + 8 * k) & 'hffff);
			w.mask = m[7:0];
			w.value = col;
			w.last = (k == c1);
			pending_writes.push_back(w);
		end
	endfunction

	always @(posedge clk) begin
		byte_write_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected write: byte_address %0d bit_mask %02h", byte_address, bit_mask);
				mismatches++;
			end else begin
				e = pending_writes.pop_front();
				if (byte_address !== e.addr) begin
					$error("byte_address: expected %0d, actual %0d", e.addr, byte_address);
					mismatches++;
				end
				if (bit_mask !== e.mask) begin
					$error("bit_mask: expected %02h, actual %02h", e.mask, bit_mask);
					mismatches++;
				end
				if (write_value !== e.value) begin
					$error("write_value: expected %0d, actual %0d", e.value, write_value);
					mismatches++;
				end
				if (last_write !== e.last) begin
					$error("last_write: expected %0d, actual %0d", e.last, last_write);
					mismatches++;
				end
			end
		end
	end

	// Write sink: a random stall before each transfer while rx_idle is set, or one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = rx_idle ? $urandom_range(0, 5) : 0;
			if (hold_outputs) begin
				gap = HOLD_CYCLES;
				hold_outputs = 1'b0;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_span(input span_row_t r);
		int gap;
		byte_write_t w;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		x_start <= r.x;
		y_line <= r.y;
		span_length <= r.len;
		pixel_colour <= r.colour;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (r.typed) begin
			if (r.typed_one) begin
				w.addr = r.typed_addr;
				w.mask = r.typed_mask;
				w.value = r.colour;
				w.last = 1'b1;
				pending_writes.push_back(w);
			end
		end else begin
			plan_span_writes(r.x, r.y, r.len, r.colour);
		end
		@(negedge clk);
	endtask

	task automatic send_random_span();
		span_row_t r;
		r = '0;
		r.x = X_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
			: $urandom_range(0, 319));
		r.y = Y_W'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: r.len = '0;
			1: r.len = LEN_W'($urandom_range(321, 511));
			2: r.len = LEN_W'($urandom_range(250, 320));
			3, 4, 5: r.len = LEN_W'($urandom_range(1, 16));
			default: r.len = LEN_W'($urandom_range(1, 96));
		endcase
		r.colour = 1'($urandom_range(0, 1));
		send_span(r);
	endtask

	// Stops offering spans until every expected write has been seen.
	task automatic drain_writes();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_writes.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_width(input logic [CPR_W-1:0] cells);
		drain_writes();
		// A zero-length span leaves nothing to wait for, so give the block time to go idle.
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cells;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		width_cells = cells;
	endtask

	initial begin
		logic [CPR_W-1:0] cells;
		// x, y, length, colour, typed, one write, address, mask (reset width of 40 cells)
		rows[0]  = '{9'd0,   8'd0,   9'd1,   1'b1, 1'b1, 1'b1, 14'd0,    8'h80};
		rows[1]  = '{9'd7,   8'd7,   9'd1,   1'b0, 1'b1, 1'b1, 14'd7,    8'h01};
		rows[2]  = '{9'd5,   8'd3,   9'd0,   1'b1, 1'b1, 1'b0, 14'd0,    8'h00};
		rows[3]  = '{9'd319, 8'd199, 9'd1,   1'b1, 1'b1, 1'b1, 14'd7999, 8'h01};
		rows[4]  = '{9'd2,   8'd0,   9'd3,   1'b1, 1'b1, 1'b1, 14'd0,    8'h38};
		rows[5]  = '{9'd8,   8'd8,   9'd8,   1'b1, 1'b1, 1'b1, 14'd328,  8'hff};
		rows[6]  = '{9'd511, 8'd0,   9'd1,   1'b0, 1'b1, 1'b1, 14'd504,  8'h01};
		rows[7]  = '{9'd0,   8'd255, 9'd8,   1'b0, 1'b1, 1'b1, 14'd9927, 8'hff};
		rows[8]  = '{9'd1,   8'd1,   9'd6,   1'b1, 1'b1, 1'b1, 14'd1,    8'h7e};
		rows[9]  = '{9'd0,   8'd0,   9'd320, 1'b1, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[10] = '{9'd3,   8'd100, 9'd320, 1'b0, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[11] = '{9'd0,   8'd0,   9'd321, 1'b1, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[12] = '{9'd511, 8'd255, 9'd511, 1'b1, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[13] = '{9'd4,   8'd0,   9'd8,   1'b1, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[14] = '{9'd6,   8'd50,  9'd4,   1'b0, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[15] = '{9'd256, 8'd128, 9'd64,  1'b1, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[16] = '{9'd100, 8'd17,  9'd2,   1'b1, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[17] = '{9'd0,   8'd0,   9'd511, 1'b0, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[18] = '{9'd7,   8'd9,   9'd2,   1'b1, 1'b0, 1'b0, 14'd0,    8'h00};
		rows[19] = '{9'd170, 8'd85,  9'd255, 1'b0, 1'b0, 1'b0, 14'd0,    8'h00};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_span(rows[i]);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: cells = 6'd1;
				1: cells = 6'd63;
				2: cells = 6'd0;
				3: cells = CPR_W'($urandom_range(2, 39));
				default: cells = CPR_W'($urandom_range(41, 62));
			endcase
			program_width(cells);
			tx_idle = (p != 1) && (p != 4);
			rx_idle = (p != 2) && (p != 4);
			for (int i = 0; i < PHASE_SPANS; i++) begin
				// The sink holds off while spans keep coming, so the block backs up.
				if (p == 0 && i == 10)
					hold_outputs = 1'b1;
				if (p == 3 && i == 25)
					drain_writes();
				send_random_span();
			end
		end

		program_width(CPR_RESET);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int i = 0; i < 10; i++)
			send_random_span();

		drain_writes();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb_cell_bitmap_hspan_fill passed");
		else
			$display("tb_cell_bitmap_hspan_fill failed");
		$finish;
	end

endmodule
